// ----- rtl/hmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hmsd_pkg
// Shared types, codes and constants of the HF modem status deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hmsd_pkg;

    // Default depth of the command queue between the front and back ends
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Input kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_START     = 2'd1;
    localparam logic [1:0] KIND_FORCE_ISS = 2'd2;
    localparam logic [1:0] KIND_FORCE_IRS = 2'd3;

    // Result kinds
    localparam logic [2:0] OUT_DATA   = 3'd0;
    localparam logic [2:0] OUT_STATUS = 3'd1;
    localparam logic [2:0] OUT_MODE   = 3'd2;
    localparam logic [2:0] OUT_FSK    = 3'd3;
    localparam logic [2:0] OUT_CALLER = 3'd4;
    localparam logic [2:0] OUT_END    = 3'd5;

    // Session roles
    localparam logic [1:0] ROLE_STANDBY = 2'd0;
    localparam logic [1:0] ROLE_SENDING = 2'd1;
    localparam logic [1:0] ROLE_RECV    = 2'd2;

    // End reasons
    localparam logic [2:0] END_NONE       = 3'd0;
    localparam logic [2:0] END_DISCONNECT = 3'd1;
    localparam logic [2:0] END_LINK_FAIL  = 3'd2;
    localparam logic [2:0] END_MODEM_RST  = 3'd3;
    localparam logic [2:0] END_PROTOCOL   = 3'd4;

    // Stream bytes and status codes
    localparam logic [7:0] BYTE_PREFIX   = 8'h80;
    localparam logic [7:0] BYTE_ESCAPE   = 8'h81;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] ST_FSK        = 8'h7a;
    localparam logic [7:0] ST_DISCONNECT = 8'h23;
    localparam logic [7:0] ST_LINK_FAIL  = 8'h24;
    localparam logic [7:0] ST_SIG_LOST   = 8'h25;
    localparam logic [7:0] ST_MODEM_RST  = 8'h09;
    localparam logic [7:0] ST_MODE       = 8'h2e;
    localparam logic [7:0] ST_CONNECT_A  = 8'h20;
    localparam logic [7:0] ST_CONNECT_B  = 8'h2b;
    localparam logic [7:0] FSK_ISS       = 8'h0e;
    localparam logic [7:0] FSK_IRS       = 8'h0f;

    // Register index of the bbs_session bit
    localparam logic REG_BBS_SESSION = 1'b0;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_value;
        logic       call_last;
        logic [1:0] role_now;
        logic       link_connected;
        logic       session_done;
        logic [2:0] end_reason;
    } t_out_item;

    // Classified command handed from the front end to the back end
    typedef struct packed {
        logic       start;
        logic       set_role;
        logic [1:0] role;
        logic       is_byte;
        logic [7:0] rx_byte;
    } t_cmd;

    // Session phase, one-hot
    typedef enum logic [3:0] {
        SESS_IDLE      = 4'b0001,
        SESS_CALLED    = 4'b0010,
        SESS_CONNECTED = 4'b0100,
        SESS_FINISHED  = 4'b1000
    } t_sess;

    // Receive framing phase, one-hot
    typedef enum logic [11:0] {
        RX_NORMAL    = 12'b0000_0000_0001,
        RX_ESC       = 12'b0000_0000_0010,
        RX_PREFIX    = 12'b0000_0000_0100,
        RX_FSK_PFX   = 12'b0000_0000_1000,
        RX_FSK_CODE  = 12'b0000_0001_0000,
        RX_MODE_PFX  = 12'b0000_0010_0000,
        RX_MODE_CODE = 12'b0000_0100_0000,
        RX_MODE_END1 = 12'b0000_1000_0000,
        RX_MODE_END2 = 12'b0001_0000_0000,
        RX_END_PFX   = 12'b0010_0000_0000,
        RX_END_ZERO  = 12'b0100_0000_0000,
        RX_CALLER    = 12'b1000_0000_0000
    } t_rx;

endpackage

`default_nettype wire

// ----- rtl/hmsd_front.sv -----
// ----------------------------------------------------------------------------
// hmsd_front
// Accepts input items, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module hmsd_front
    import hmsd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_pop,
    output t_cmd          o_cmd
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_cmd             w_cmd;
    logic             w_push;
    logic             w_pop;

    // Classify the incoming item
    always_comb begin
        w_cmd          = '0;
        w_cmd.rx_byte  = i_in_item.rx_byte;
        unique case (i_in_item.kind)
            KIND_BYTE:      w_cmd.is_byte = 1'b1;
            KIND_START:     w_cmd.start   = 1'b1;
            KIND_FORCE_ISS: begin
                w_cmd.set_role = 1'b1;
                w_cmd.role     = ROLE_SENDING;
            end
            KIND_FORCE_IRS: begin
                w_cmd.set_role = 1'b1;
                w_cmd.role     = ROLE_RECV;
            end
            default:        w_cmd.is_byte = 1'b1;
        endcase
    end

    assign o_in_ready  = (r_count != CNT_FULL);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    // Advance the pointers and the fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the classified command
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hmsd_back.sv -----
// ----------------------------------------------------------------------------
// hmsd_back
// Runs the session and framing state machines on queued commands and holds
// the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hmsd_back
    import hmsd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_bbs_session,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_pop,
    input  wire t_cmd i_cmd,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_item o_out_item
);

    t_sess      r_sess, n_sess;
    t_rx        r_rx, n_rx;
    logic [7:0] r_pend_status, n_pend_status;
    logic [7:0] r_pend_mode, n_pend_mode;
    logic [1:0] r_role, n_role;
    logic       r_link, n_link;
    logic [2:0] r_end, n_end;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       w_emit;
    logic [2:0] w_kind;
    logic [7:0] w_value;
    logic       w_last;
    logic [7:0] w_b;

    assign o_cmd_pop = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign w_b       = i_cmd.rx_byte;

    // Step the state machines for one command
    always_comb begin
        n_sess        = r_sess;
        n_rx          = r_rx;
        n_pend_status = r_pend_status;
        n_pend_mode   = r_pend_mode;
        n_role        = r_role;
        n_link        = r_link;
        n_end         = r_end;
        w_emit        = 1'b0;
        w_kind        = OUT_DATA;
        w_value       = w_b;
        w_last        = 1'b0;
        if (o_cmd_pop) begin
            if (i_cmd.start) begin
                n_sess = SESS_CALLED;
                n_rx   = RX_NORMAL;
                n_link = 1'b0;
                n_end  = END_NONE;
            end else if (i_cmd.set_role) begin
                n_role = i_cmd.role;
            end else if (i_cmd.is_byte &&
                         (r_sess == SESS_CALLED || r_sess == SESS_CONNECTED)) begin
                unique case (r_rx)
                    RX_NORMAL: begin
                        if (w_b == BYTE_PREFIX) begin
                            n_rx = RX_PREFIX;
                        end else if (w_b == BYTE_ESCAPE) begin
                            n_rx = RX_ESC;
                        end else begin
                            w_emit = 1'b1;
                        end
                    end
                    RX_ESC: begin
                        n_rx   = RX_NORMAL;
                        w_emit = 1'b1;
                    end
                    RX_PREFIX: begin
                        n_rx = RX_NORMAL;
                        if (w_b == ST_FSK) begin
                            n_rx = RX_FSK_PFX;
                        end else if (w_b == ST_MODEM_RST) begin
                            n_sess = SESS_FINISHED;
                            n_end  = END_MODEM_RST;
                            w_emit = 1'b1;
                            w_kind = OUT_END;
                        end else begin
                            w_emit = 1'b1;
                            w_kind = OUT_STATUS;
                            if (w_b == ST_MODE) begin
                                n_rx = RX_MODE_PFX;
                            end else if (w_b == ST_DISCONNECT || w_b == ST_LINK_FAIL ||
                                         w_b == ST_SIG_LOST) begin
                                n_pend_status = w_b;
                                n_rx          = RX_END_PFX;
                            end else if ((w_b == ST_CONNECT_A || w_b == ST_CONNECT_B) &&
                                         (i_bbs_session || r_sess == SESS_CALLED)) begin
                                if (i_bbs_session) begin
                                    n_rx = RX_CALLER;
                                end else begin
                                    n_sess = SESS_CONNECTED;
                                    n_link = 1'b1;
                                end
                            end
                        end
                    end
                    RX_FSK_CODE: begin
                        if (w_b == FSK_ISS) begin
                            n_role = ROLE_SENDING;
                        end else if (w_b == FSK_IRS) begin
                            n_role = ROLE_RECV;
                        end
                        n_rx   = RX_NORMAL;
                        w_emit = 1'b1;
                        w_kind = OUT_FSK;
                    end
                    RX_MODE_CODE: begin
                        n_pend_mode = w_b;
                        n_rx        = RX_MODE_END1;
                    end
                    RX_FSK_PFX, RX_MODE_PFX, RX_MODE_END1, RX_END_PFX: begin
                        // Expect a prefix byte
                        if (w_b != BYTE_PREFIX) begin
                            n_sess = SESS_FINISHED;
                            n_rx   = RX_NORMAL;
                            n_end  = END_PROTOCOL;
                            w_emit = 1'b1;
                            w_kind = OUT_END;
                        end else if (r_rx == RX_FSK_PFX) begin
                            n_rx = RX_FSK_CODE;
                        end else if (r_rx == RX_MODE_PFX) begin
                            n_rx = RX_MODE_CODE;
                        end else if (r_rx == RX_MODE_END1) begin
                            n_rx = RX_MODE_END2;
                        end else begin
                            n_rx = RX_END_ZERO;
                        end
                    end
                    RX_MODE_END2, RX_END_ZERO: begin
                        // Expect the closing zero
                        n_rx = RX_NORMAL;
                        if (w_b != BYTE_ZERO) begin
                            n_sess = SESS_FINISHED;
                            n_end  = END_PROTOCOL;
                            w_emit = 1'b1;
                            w_kind = OUT_END;
                        end else if (r_rx == RX_MODE_END2) begin
                            w_emit  = 1'b1;
                            w_kind  = OUT_MODE;
                            w_value = r_pend_mode;
                        end else if (r_pend_status == ST_DISCONNECT ||
                                     r_pend_status == ST_LINK_FAIL) begin
                            n_sess  = SESS_FINISHED;
                            n_end   = (r_pend_status == ST_DISCONNECT) ?
                                      END_DISCONNECT : END_LINK_FAIL;
                            w_emit  = 1'b1;
                            w_kind  = OUT_END;
                            w_value = r_pend_status;
                        end
                    end
                    RX_CALLER: begin
                        if (w_b == BYTE_ZERO) begin
                            n_link = 1'b1;
                            n_rx   = RX_NORMAL;
                            w_emit = 1'b1;
                            w_kind = OUT_CALLER;
                            w_last = 1'b1;
                        end else if (w_b != BYTE_PREFIX) begin
                            w_emit = 1'b1;
                            w_kind = OUT_CALLER;
                        end
                    end
                    default: n_rx = RX_NORMAL;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess        <= SESS_IDLE;
            r_rx          <= RX_NORMAL;
            r_pend_status <= '0;
            r_pend_mode   <= '0;
            r_role        <= ROLE_STANDBY;
            r_link        <= 1'b0;
            r_end         <= END_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            r_sess        <= n_sess;
            r_rx          <= n_rx;
            r_pend_status <= n_pend_status;
            r_pend_mode   <= n_pend_mode;
            r_role        <= n_role;
            r_link        <= n_link;
            r_end         <= n_end;
            if (o_cmd_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result with the state after the step
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && w_emit) begin
            r_out.out_kind       <= w_kind;
            r_out.out_value      <= w_value;
            r_out.call_last      <= w_last;
            r_out.role_now       <= n_role;
            r_out.link_connected <= n_link;
            r_out.session_done   <= (n_sess == SESS_FINISHED);
            r_out.end_reason     <= n_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ----- rtl/hf_modem_status_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// hf_modem_status_deframer_unit
// Splits the modem receive stream into data bytes and status frames.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------
//  in       | input     | i_in_valid/o_in_ready  | i_in_item (t_in_item)
//  out      | output    | o_out_valid/i_out_ready| o_out_item (t_out_item)
//  config   | input     | psel/penable/pready    | paddr, pwdata, prdata
//
// One item per cycle sustained while the output side does not stall; an item
// is written into the queue, then popped and stepped into the output register.
// Reset is synchronous and clears the queue, the session state and the
// bbs_session register. The queue absorbs up to QUEUE_DEPTH items while
// the output side stalls; the input stalls only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module hf_modem_status_deframer_unit
    import hmsd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic r_bbs;
    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    // Register write and read-back
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BBS_SESSION) ? {31'b0, r_bbs} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bbs <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_BBS_SESSION) begin
            r_bbs <= pwdata[0];
        end
    end

    hmsd_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_cmd_valid(w_cmd_valid),
        .i_cmd_pop  (w_cmd_pop),
        .o_cmd      (w_cmd)
    );

    hmsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bbs_session(r_bbs),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_pop    (w_cmd_pop),
        .i_cmd        (w_cmd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire

// ----- rtl/hmsd_checker.sv -----
// ----------------------------------------------------------------------------
// hmsd_checker
// Port-level checks of the deframer's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module hmsd_checker
    import hmsd_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // Hold a stalled transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

    // A finished session always carries a reason
    a_done_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.session_done |-> o_out_item.end_reason != END_NONE)
        else $error("session done without end reason");

    // A session end result marks the session done
    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.out_kind == OUT_END |-> o_out_item.session_done)
        else $error("session end result without session done");

    // The callsign terminator is a zero caller char with the link up
    a_call_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.call_last |->
            o_out_item.out_kind == OUT_CALLER && o_out_item.out_value == BYTE_ZERO &&
            o_out_item.link_connected)
        else $error("malformed callsign terminator");

endmodule

bind hf_modem_status_deframer_unit hmsd_checker u_hmsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_item (o_out_item)
);

`default_nettype wire
